// ===== rtl/core/envelope_driven_waveshaper_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the envelope driven waveshaper core
// Every user module has clk and rst_n; checks are off while reset is low.
// ---------------------------------------------------------------------------
`ifndef ENVELOPE_DRIVEN_WAVESHAPER_CORE_MACROS_SVH
`define ENVELOPE_DRIVEN_WAVESHAPER_CORE_MACROS_SVH

// same-cycle implication
`define EDWS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edws same-cycle check failed");

// next-cycle implication
`define EDWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edws next-cycle check failed");

`endif

// ===== rtl/core/edws_pkg.sv =====
// ---------------------------------------------------------------------------
// edws_pkg
// Shared types, codes, reset values and the shaping curve generator.
// ---------------------------------------------------------------------------
package edws_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int ENV_W       = 24;
  localparam int GAIN_W      = 41;
  localparam int CFG_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd64185;
  localparam logic [COEF_W-1:0] RELEASE_RST = 16'd65519;
  localparam logic [COEF_W-1:0] BASE_RST    = 16'd4096;
  localparam logic [COEF_W-1:0] DEPTH_RST   = 16'd4096;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [63:0] Q28_ONE = 64'h1000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 4'd0,
    CFG_RELEASE = 4'd1,
    CFG_BASE    = 4'd2,
    CFG_DEPTH   = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] release_coef;
    logic [COEF_W-1:0] drive_base;
    logic [COEF_W-1:0] drive_depth;
  } cfg_t;

  typedef struct packed {
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
  } mid_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_MIX,
    BS_ENV,
    BS_GAIN,
    BS_DRV,
    BS_SAT,
    BS_IDX,
    BS_RD0,
    BS_RD1,
    BS_MUL,
    BS_OUT
  } bst_t;

  // shift-subtract quotient, num must be below 2**nbits
  function automatic logic [63:0] udiv_q(input logic [63:0] num, input logic [63:0] den,
                                         input int nbits);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = nbits - 1; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_q28(input logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q28_ONE;
    term = Q28_ONE;
    for (int n = 1; n <= 40; n++) begin
      term = udiv_q((term * z) >> 28, 64'(n), 36);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] half_tanh_q28(input logic [63:0] z);
    logic [63:0] e;
    e = exp_q28(z);
    return udiv_q((e - Q28_ONE) << 28, e + Q28_ONE, 64);
  endfunction

  // curve entry idx of a table with size entries, Q1.15
  function automatic logic [SAMPLE_W-1:0] curve_entry(input int idx, input int size);
    longint      m;
    logic [63:0] am;
    logic [63:0] z;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] res;
    m = 2 * longint'(idx) - longint'(size - 1);
    if (m >= 0) begin
      am  = 64'(m);
      z   = udiv_q((am * 64'd3) << 28, 64'(size - 1), 48);
      t   = half_tanh_q28(z);
      q   = (t * 64'd32768 + (64'd1 << 27)) >> 28;
      res = q;
    end else begin
      am  = 64'(-m);
      z   = udiv_q((am * 64'd14) << 28, 64'(size - 1) * 64'd10, 48);
      t   = half_tanh_q28(z);
      t   = udiv_q(t * 64'd9, 64'd10, 40);
      q   = (t * 64'd32768 + (64'd1 << 27)) >> 28;
      res = 64'd0 - q;
    end
    return res[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/edws_ram.sv =====
// ---------------------------------------------------------------------------
// edws_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module edws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/edws_fifo.sv =====
// ---------------------------------------------------------------------------
// edws_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module edws_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  `include "envelope_driven_waveshaper_core_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `EDWS_ASSERT_IMPL(a_no_push_full, push, !full)
  `EDWS_ASSERT_IMPL(a_count_in_range, 1'b1, count_r <= CW'(DEPTH))

endmodule

// ===== rtl/core/edws_front.sv =====
// ---------------------------------------------------------------------------
// edws_front
// Input stage: takes samples and splits them into sign and magnitude.
// ---------------------------------------------------------------------------
module edws_front
  import edws_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       q_full,
  output logic                       q_push,
  output mid_t                       q_data
);

  logic vld_r;
  logic vld_nxt;
  mid_t item_r;
  mid_t item_nxt;
  logic take;

  assign full   = !en || (vld_r && q_full);
  assign take   = push && !full;
  assign q_push = vld_r && !q_full;
  assign q_data = item_r;

  always_comb begin
    item_nxt.neg = sample_in[SAMPLE_W-1];
    item_nxt.mag = sample_in[SAMPLE_W-1] ? (~sample_in + SAMPLE_W'(1)) : sample_in;
    vld_nxt      = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/edws_curve.sv =====
// ---------------------------------------------------------------------------
// edws_curve
// Shaping curve store: loads the table RAM after reset, then serves reads.
// ---------------------------------------------------------------------------
module edws_curve
  import edws_pkg::*;
#(
  parameter int TABLE_SIZE = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  output logic [SAMPLE_W-1:0]           rd_data,
  output logic                          ready
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SIZE - 1);

  logic [SAMPLE_W-1:0] rom_word [TABLE_SIZE];
  logic [AW-1:0]       fill_cnt_r;
  logic                ready_r;

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
    localparam logic [SAMPLE_W-1:0] CurveVal = curve_entry(gi, TABLE_SIZE);
    assign rom_word[gi] = CurveVal;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
      ready_r    <= 1'b0;
    end else if (!ready_r) begin
      if (fill_cnt_r == LastIdx) begin
        ready_r <= 1'b1;
      end else begin
        fill_cnt_r <= fill_cnt_r + AW'(1);
      end
    end
  end

  edws_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (!ready_r),
    .waddr (fill_cnt_r),
    .wdata (rom_word[fill_cnt_r]),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign ready = ready_r;

endmodule

// ===== rtl/core/edws_back.sv =====
// ---------------------------------------------------------------------------
// edws_back
// Sequencer: envelope update, drive, saturation, table lookup, interpolation.
// ---------------------------------------------------------------------------
module edws_back
  import edws_pkg::*;
#(
  parameter int TABLE_SIZE = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          tbl_ready,
  output logic [$clog2(TABLE_SIZE)-1:0] tbl_rd_addr,
  input  logic [SAMPLE_W-1:0]           tbl_rd_data,
  input  logic                          mid_empty,
  input  mid_t                          mid_data,
  output logic                          mid_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output logic [SAMPLE_W-1:0]           res_data
);

  `include "envelope_driven_waveshaper_core_macros.svh"

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int PW = 32 + AW;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SIZE - 1);
  localparam logic signed [48:0] RndHalf = 49'sd1 <<< 30;

  bst_t state_r;
  bst_t state_nxt;

  logic                       neg_r;
  logic [SAMPLE_W-1:0]        mag_r;
  logic [ENV_W-1:0]           env_r;
  logic [ENV_W-1:0]           env_nxt;
  logic [39:0]                pe_r;
  logic [39:0]                pe_nxt;
  logic [40:0]                pa_r;
  logic [40:0]                pa_nxt;
  logic [GAIN_W-1:0]          gain_r;
  logic [GAIN_W-1:0]          gain_nxt;
  logic [39:0]                pl_r;
  logic [39:0]                pl_nxt;
  logic [32:0]                ph_r;
  logic [32:0]                ph_nxt;
  logic [31:0]                u_r;
  logic [31:0]                u_nxt;
  logic [AW-1:0]              idx_r;
  logic [30:0]                frac_r;
  logic signed [SAMPLE_W-1:0] lo_r;
  logic signed [48:0]         prod_r;
  logic signed [48:0]         prod_nxt;

  logic [ENV_W-1:0]   a_val;
  logic [COEF_W-1:0]  coef;
  logic [16:0]        coef_inv;
  logic [40:0]        mix_sum;
  logic [39:0]        dd_prod;
  logic [56:0]        dfull;
  logic [36:0]        dmag;
  logic [30:0]        dsat;
  logic [PW-1:0]      pos;
  logic signed [16:0] diff;
  logic signed [31:0] frac_s;
  logic signed [48:0] rnd;
  logic [17:0]        res_sum;

  // envelope mix
  assign a_val    = {mag_r, 8'd0};
  assign coef     = (a_val > env_r) ? cfg.attack_coef : cfg.release_coef;
  assign coef_inv = 17'h10000 - {1'b0, coef};
  assign pe_nxt   = coef * env_r;
  assign pa_nxt   = coef_inv * a_val;
  assign mix_sum  = {1'b0, pe_r} + pa_r;
  assign env_nxt  = mix_sum[39:16];

  // drive gain and driven magnitude
  assign dd_prod  = cfg.drive_depth * env_r;
  assign gain_nxt = {2'b00, cfg.drive_base, 23'd0} + {1'b0, dd_prod};
  assign pl_nxt   = mag_r * gain_r[23:0];
  assign ph_nxt   = mag_r * gain_r[40:24];
  assign dfull    = {ph_r, 24'd0} + {17'd0, pl_r};
  assign dmag     = dfull[56:20];
  assign dsat     = (dmag > {6'd0, Q30_ONE}) ? Q30_ONE : dmag[30:0];
  assign u_nxt    = neg_r ? ({1'b0, Q30_ONE} - {1'b0, dsat}) : ({1'b0, Q30_ONE} + {1'b0, dsat});

  // table position
  assign pos = PW'(u_r) * PW'(LastIdx);

  // interpolation
  assign diff     = {tbl_rd_data[SAMPLE_W-1], tbl_rd_data} - {lo_r[SAMPLE_W-1], lo_r};
  assign frac_s   = {1'b0, frac_r};
  assign prod_nxt = diff * frac_s;
  assign rnd      = prod_r + RndHalf;
  assign res_sum  = {{2{lo_r[SAMPLE_W-1]}}, lo_r} + rnd[48:31];
  assign res_data = res_sum[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mid_pop     = 1'b0;
    res_push    = 1'b0;
    tbl_rd_addr = idx_r;
    case (state_r)
      BS_IDLE: begin
        if (tbl_ready && !mid_empty && !res_full) begin
          mid_pop   = 1'b1;
          state_nxt = BS_MIX;
        end
      end
      BS_MIX:  state_nxt = BS_ENV;
      BS_ENV:  state_nxt = BS_GAIN;
      BS_GAIN: state_nxt = BS_DRV;
      BS_DRV:  state_nxt = BS_SAT;
      BS_SAT:  state_nxt = BS_IDX;
      BS_IDX:  state_nxt = BS_RD0;
      BS_RD0:  state_nxt = BS_RD1;
      BS_RD1: begin
        tbl_rd_addr = (idx_r == LastIdx) ? idx_r : idx_r + AW'(1);
        state_nxt   = BS_MUL;
      end
      BS_MUL:  state_nxt = BS_OUT;
      BS_OUT: begin
        res_push  = 1'b1;
        state_nxt = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (state_r == BS_ENV) begin
      env_r <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        if (mid_pop) begin
          neg_r <= mid_data.neg;
          mag_r <= mid_data.mag;
        end
      end
      BS_MIX: begin
        pe_r <= pe_nxt;
        pa_r <= pa_nxt;
      end
      BS_GAIN: gain_r <= gain_nxt;
      BS_DRV: begin
        pl_r <= pl_nxt;
        ph_r <= ph_nxt;
      end
      BS_SAT: u_r <= u_nxt;
      BS_IDX: begin
        idx_r  <= pos[31 +: AW];
        frac_r <= pos[30:0];
      end
      BS_RD1: lo_r <= tbl_rd_data;
      BS_MUL: prod_r <= prod_nxt;
      default: ;
    endcase
  end

  `EDWS_ASSERT_IMPL(a_busy_needs_table, state_r != BS_IDLE, tbl_ready)
  `EDWS_ASSERT_IMPL(a_result_slot_held, state_r == BS_OUT, !res_full)
  `EDWS_ASSERT_NEXT(a_env_only_in_update, state_r != BS_ENV, $stable(env_r))

endmodule

// ===== rtl/core/envelope_driven_waveshaper_core.sv =====
// ---------------------------------------------------------------------------
// envelope_driven_waveshaper_core
// Peak-envelope driven tanh waveshaper for signed Q1.15 audio samples.
// ---------------------------------------------------------------------------
// Input queue side: a sample beat is taken when push is high and full low.
// Result queue side: out_sample_out holds the oldest result while empty is
// low; the beat completes when pop is high and empty low. One result per
// input sample, in order.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 attack_coef,
// 1 release_coef, 2 drive_base, 3 drive_depth); other indexes are ignored.
// Write only while no sample is in flight.
// Sequencing: samples go one at a time through the multi-step sequencer
// that runs envelope, drive, lookup and interpolation on one shared path;
// it takes a new sample only after the last result has been pushed.
// Reset: registers take their defaults, the envelope clears, and the curve
// table is loaded into RAM entry by entry; full stays high meanwhile.
// Stall: an input register, a two-entry middle queue and a two-entry result
// queue absorb samples while pop is low; full rises once they are taken up.
// ---------------------------------------------------------------------------
module envelope_driven_waveshaper_core
  import edws_pkg::*;
#(
  parameter int TABLE_SIZE = 2048
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_wdata
);

  localparam int AW = $clog2(TABLE_SIZE);

  cfg_t                cfg_r;
  logic                tbl_ready;
  logic [AW-1:0]       tbl_rd_addr;
  logic [SAMPLE_W-1:0] tbl_rd_data;
  logic                q_full;
  logic                q_push;
  mid_t                q_wdata;
  logic                mid_empty;
  logic                mid_pop;
  logic [$bits(mid_t)-1:0] mid_rdata;
  logic                res_full;
  logic                res_push;
  logic [SAMPLE_W-1:0] res_data;
  logic [SAMPLE_W-1:0] out_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coef  <= ATTACK_RST;
      cfg_r.release_coef <= RELEASE_RST;
      cfg_r.drive_base   <= BASE_RST;
      cfg_r.drive_depth  <= DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  cfg_r.attack_coef  <= cfg_wdata;
        CFG_RELEASE: cfg_r.release_coef <= cfg_wdata;
        CFG_BASE:    cfg_r.drive_base   <= cfg_wdata;
        CFG_DEPTH:   cfg_r.drive_depth  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  edws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (tbl_ready),
    .push      (push),
    .full      (full),
    .sample_in (in_sample_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  edws_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  edws_curve #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_curve (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .ready   (tbl_ready)
  );

  edws_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .tbl_ready   (tbl_ready),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_data (tbl_rd_data),
    .mid_empty   (mid_empty),
    .mid_data    (mid_t'(mid_rdata)),
    .mid_pop     (mid_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  edws_fifo #(
    .WIDTH (SAMPLE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_word),
    .empty (empty)
  );

  assign out_sample_out = out_word;

endmodule

// ===== dv/tb_envelope_driven_waveshaper_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_envelope_driven_waveshaper_core
// Self-checking bench for the envelope driven waveshaper. A scoreboard class
// tracks the peak envelope and the tanh curve on its own and predicts every
// shaped sample. Directed edge samples are followed by random audio-like
// streams under several register settings. Both queue sides idle at random,
// and the result side holds off long enough to back up the input.
// ---------------------------------------------------------------------------
module tb_envelope_driven_waveshaper_core;
  import edws_pkg::*;

  localparam int TABLE_SIZE    = 2048;
  localparam int ITEMS_PER_SET = 130;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 12000;
  localparam int HOLD_CYCLES   = 150;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  typedef longint unsigned u64_t;

  class shaped_sample_board;
    logic [COEF_W-1:0]          att_coef;
    logic [COEF_W-1:0]          rel_coef;
    logic [COEF_W-1:0]          base_gain;
    logic [COEF_W-1:0]          depth_gain;
    logic [ENV_W-1:0]           env_level;
    logic signed [SAMPLE_W-1:0] curve [TABLE_SIZE];
    logic signed [SAMPLE_W-1:0] expected_shaped [$];
    int                         mismatches;

    function new();
      att_coef   = ATTACK_RST;
      rel_coef   = RELEASE_RST;
      base_gain  = BASE_RST;
      depth_gain = DEPTH_RST;
      env_level  = '0;
      mismatches = 0;
      fill_curve();
    endfunction

    function longint unsigned exp_series(longint unsigned z);
      longint unsigned acc;
      longint unsigned term;
      acc  = Q28_ONE;
      term = Q28_ONE;
      for (longint unsigned n = 1; n <= 40; n++) begin
        term = ((term * z) >> 28) / n;
        acc  = acc + term;
      end
      return acc;
    endfunction

    function longint unsigned tanh_of_half(longint unsigned z);
      longint unsigned e;
      e = exp_series(z);
      return ((e - Q28_ONE) << 28) / (e + Q28_ONE);
    endfunction

    function void fill_curve();
      longint          m;
      longint unsigned span;
      longint unsigned z;
      longint unsigned t;
      longint unsigned q;
      span = TABLE_SIZE - 1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        m = 2 * longint'(i) - longint'(span);
        if (m >= 0) begin
          z = ((u64_t'(m) * 3) << 28) / span;
          t = tanh_of_half(z);
          q = (t * 32768 + (64'd1 << 27)) >> 28;
          curve[i] = q[SAMPLE_W-1:0];
        end else begin
          z = ((u64_t'(-m) * 14) << 28) / (span * 10);
          t = tanh_of_half(z);
          t = (t * 9) / 10;
          q = (t * 32768 + (64'd1 << 27)) >> 28;
          curve[i] = -q[SAMPLE_W-1:0];
        end
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        CFG_ATTACK:  att_coef   = val;
        CFG_RELEASE: rel_coef   = val;
        CFG_BASE:    base_gain  = val;
        CFG_DEPTH:   depth_gain = val;
        default: ;
      endcase
    endfunction

    function logic signed [SAMPLE_W-1:0] shape_sample(logic signed [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] raw;
      logic                neg;
      longint unsigned     mag;
      longint unsigned     a;
      longint unsigned     c;
      longint unsigned     gain;
      longint unsigned     dmag;
      longint unsigned     u;
      longint unsigned     p;
      longint unsigned     f;
      longint unsigned     idx;
      longint              driven;
      longint              lo;
      longint              hi;
      longint              v;
      logic signed [SAMPLE_W-1:0] res;
      raw = s;
      neg = raw[SAMPLE_W-1];
      mag = neg ? (64'd65536 - raw) : raw;
      a   = mag << 8;
      c   = (a > env_level) ? att_coef : rel_coef;
      env_level = ENV_W'((c * env_level + (64'd65536 - c) * a) >> 16);
      gain = (u64_t'(base_gain) << 23) + u64_t'(depth_gain) * env_level;
      dmag = (mag * gain) >> 20;
      if (dmag > (64'd1 << 30)) dmag = 64'd1 << 30;
      driven = neg ? -longint'(dmag) : longint'(dmag);
      u   = u64_t'(driven + (64'sd1 <<< 30));
      p   = u * (TABLE_SIZE - 1);
      idx = p >> 31;
      f   = p & 64'h7FFF_FFFF;
      if (idx >= TABLE_SIZE - 1) begin
        res = curve[TABLE_SIZE-1];
      end else begin
        lo = curve[idx];
        hi = curve[idx+1];
        v  = lo * (64'sd1 <<< 31) + (hi - lo) * longint'(f);
        v  = v + (64'sd1 <<< 50) + (64'sd1 <<< 30);
        res = SAMPLE_W'((v >> 31) - (64'sd1 <<< 19));
      end
      return res;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      expected_shaped.push_back(shape_sample(s));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_shaped.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no sample pending", got));
      end else begin
        want = expected_shaped.pop_front();
        if (got !== want)
          report_mismatch($sformatf("sample_out got %0d expected %0d", got, want));
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       push;
  logic                       full;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       empty;
  logic                       pop;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COEF_W-1:0]          cfg_wdata;

  shaped_sample_board sb;
  bit                 no_idle = 1'b0;
  int                 burst_amp = 8192;
  int                 stall_cycles = 0;

  envelope_driven_waveshaper_core #(.TABLE_SIZE(TABLE_SIZE)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_sample_in  (in_sample_in),
    .empty         (empty),
    .pop           (pop),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (push && !full) sb.note_sample(in_sample_in);
      if (pop && !empty) sb.check_result(out_sample_out);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random pop idling plus a few long hold-offs
  initial begin : result_side
    int popped;
    popped = 0;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (popped == 90 || popped == 330 || popped == 560) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        popped++;
      end
      pop <= no_idle || ($urandom_range(99) >= 13);
      @(posedge clk);
      if (pop && !empty) popped++;
    end
  end

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(input cfg_t s, input bit with_spare);
    cfg_we <= 1'b1;
    cfg_beat(CFG_ATTACK, s.attack_coef);
    cfg_beat(CFG_RELEASE, s.release_coef);
    cfg_beat(CFG_BASE, s.drive_base);
    cfg_beat(CFG_DEPTH, s.drive_depth);
    if (with_spare) begin
      cfg_beat(CFG_SPARE_LO, COEF_W'($urandom));
      cfg_beat(CFG_SPARE_HI, COEF_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s);
    in_sample_in <= s;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    if (!no_idle && $urandom_range(99) < 13) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_block();
    push <= 1'b0;
    @(posedge clk);
    while (sb.expected_shaped.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] audio_sample();
    logic signed [SAMPLE_W-1:0] s;
    if ($urandom_range(19) == 0) begin
      case ($urandom_range(3))
        0: burst_amp = 64;
        1: burst_amp = 1024;
        2: burst_amp = 8192;
        default: burst_amp = 32767;
      endcase
    end
    case ($urandom_range(9))
      0, 1, 2: s = SAMPLE_W'($urandom);
      3, 4, 5, 6: s = SAMPLE_W'($urandom_range(0, 2 * burst_amp) - burst_amp);
      7: s = SAMPLE_W'($urandom_range(0, 256) - 128);
      default: begin
        case ($urandom_range(3))
          0: s = 16'sh7FFF;
          1: s = 16'sh8000;
          2: s = 16'sh0000;
          default: s = -16'sd1;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic cfg_t set_for_phase(input int phase);
    cfg_t s;
    case (phase)
      1: begin
        s.attack_coef  = 16'h0000;
        s.release_coef = 16'hFFFF;
        s.drive_base   = 16'd4096;
        s.drive_depth  = 16'hFFFF;
      end
      2: begin
        s.attack_coef  = 16'hFFFF;
        s.release_coef = 16'h0000;
        s.drive_base   = 16'hFFFF;
        s.drive_depth  = 16'h0000;
      end
      3: begin
        s.attack_coef  = COEF_W'($urandom);
        s.release_coef = COEF_W'($urandom);
        s.drive_base   = 16'h0000;
        s.drive_depth  = COEF_W'($urandom);
      end
      4: begin
        s.attack_coef  = COEF_W'($urandom);
        s.release_coef = COEF_W'($urandom);
        s.drive_base   = COEF_W'($urandom);
        s.drive_depth  = COEF_W'($urandom);
      end
      default: begin
        s.attack_coef  = ATTACK_RST;
        s.release_coef = RELEASE_RST;
        s.drive_base   = BASE_RST;
        s.drive_depth  = DEPTH_RST;
      end
    endcase
    return s;
  endfunction

  initial begin : sample_side
    logic signed [SAMPLE_W-1:0] edge_samples [$];
    sb = new();
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_sample_in <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_ATTACK;
    cfg_wdata    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);

    // reset values again, plus writes to unused indexes that must be ignored
    program_regs(set_for_phase(0), 1'b1);

    // extremes, attack run into saturation and the top of the table, release
    edge_samples = '{16'sh0000, 16'sh0001, -16'sd1, 16'sh7FFF, 16'sh8000,
                     16'sh4000, -16'sh4000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                     16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000,
                     16'sh0000, 16'sd100, -16'sd100, 16'sh5555, 16'shAAAA,
                     16'sh7FFF};
    foreach (edge_samples[i]) offer_sample(edge_samples[i]);
    drain_block();

    for (int phase = 1; phase <= 5; phase++) begin
      program_regs(set_for_phase(phase), phase == 4);
      no_idle = (phase == 2);
      repeat (ITEMS_PER_SET) offer_sample(audio_sample());
      no_idle = 1'b0;
      drain_block();
    end

    if (sb.mismatches == 0 && sb.expected_shaped.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
